### rtl/ubds_pkg.sv
// ubds_pkg: widths, limits and prescaler table for the uart baud divisor search
// no dependencies; used by ubds_divider and uart_baud_divisor_search_top
`timescale 1ns / 1ps
`default_nettype none

package ubds_pkg;

    localparam int BAUD_W  = 24;
    localparam int CLK_W   = 28;
    localparam int CODE_W  = 4;
    localparam int DREG_W  = 16;

    // shared divider: dividend covers sclk + baud/2, divisor covers the baud rate
    localparam int DVD_W   = 30;
    localparam int DVS_W   = 24;
    localparam int CNT_W   = $clog2(DVD_W);

    localparam int SCLK_W  = CLK_W + 1;
    localparam int GEN_W   = SCLK_W - 4;
    localparam int FACT_W  = 9;

    localparam int TOL_L_W = GEN_W + 14;

    localparam logic [CODE_W-1:0] LAST_CODE = 4'hF;
    localparam logic [DVD_W-1:0]  DIV_MIN   = 30'h10;
    localparam logic [DVD_W-1:0]  DIV_MAX   = 30'hFFFF;
    localparam logic [13:0]       TOL_DEN   = 14'd5000;
    localparam logic [6:0]        TOL_NUM   = 7'd91;

    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DVD_W-1:0] quotient;
    } t_div_rsp;

    function automatic logic [FACT_W-1:0] presc_factor(input logic [CODE_W-1:0] code);
        logic [FACT_W-1:0] f;
        case (code)
            4'd0:    f = 9'd1;
            4'd1:    f = 9'd2;
            4'd2:    f = 9'd4;
            4'd3:    f = 9'd6;
            4'd4:    f = 9'd8;
            4'd5:    f = 9'd10;
            4'd6:    f = 9'd12;
            4'd7:    f = 9'd16;
            4'd8:    f = 9'd32;
            4'd9:    f = 9'd64;
            4'd10:   f = 9'd128;
            default: f = 9'd256;
        endcase
        return f;
    endfunction

endpackage

`default_nettype wire

### rtl/ubds_divider.sv
// ubds_divider: restoring unsigned divider, one quotient bit per cycle
// depends on ubds_pkg (widths, request and response structs)
`timescale 1ns / 1ps
`default_nettype none

module ubds_divider (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  ubds_pkg::t_div_req  i_req,
    output ubds_pkg::t_div_rsp  o_rsp
);

    logic                          r_busy, n_busy;
    logic                          r_done, n_done;
    logic [ubds_pkg::CNT_W-1:0]    r_cnt, n_cnt;
    logic [ubds_pkg::DVS_W-1:0]    r_rem, n_rem;
    logic [ubds_pkg::DVD_W-1:0]    r_quo, n_quo;
    logic [ubds_pkg::DVS_W-1:0]    r_dvs, n_dvs;
    logic [ubds_pkg::DVS_W+1:0]    w_sub;

    // dividend shifts out of the top of r_quo while quotient bits shift in
    assign w_sub = {1'b0, r_rem, r_quo[ubds_pkg::DVD_W-1]} - {2'b00, r_dvs};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_dvs  = r_dvs;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = ubds_pkg::CNT_W'(ubds_pkg::DVD_W - 1);
            n_rem  = '0;
            n_quo  = i_req.dividend;
            n_dvs  = i_req.divisor;
        end else if (r_busy) begin
            if (w_sub[ubds_pkg::DVS_W+1]) begin
                n_rem = {r_rem[ubds_pkg::DVS_W-2:0], r_quo[ubds_pkg::DVD_W-1]};
                n_quo = {r_quo[ubds_pkg::DVD_W-2:0], 1'b0};
            end else begin
                n_rem = w_sub[ubds_pkg::DVS_W-1:0];
                n_quo = {r_quo[ubds_pkg::DVD_W-2:0], 1'b1};
            end
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_cnt = r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dvs <= n_dvs;
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

`default_nettype wire

### rtl/uart_baud_divisor_search_top.sv
// uart_baud_divisor_search_top: sequencer that searches prescaler codes for a baud divisor
// depends on ubds_pkg and ubds_divider
`timescale 1ns / 1ps
`default_nettype none

// One item (target baud, input clock, oversampling mode) yields one result: the first
// prescaler code 0..15 whose rounded divisor lies in 16..65535 with a rate error of at
// most 1.82 percent, and the packed divisor register value, or found = 0 with code 15
// and divisor 0. All arithmetic runs through one restoring divider that produces one
// quotient bit per cycle (30 bits, with a hand-off between divisions). Each code tried
// costs two divisions when its divisor is out of range and three plus a tolerance
// check otherwise, so an item is quickest when the first code is accepted and slowest
// when all sixteen codes are tried with their divisors in range; a zero baud rate skips
// the divisions and goes straight to the result. The block takes no new item while a
// search runs; a finished result waits in the output register while the next item is
// accepted.
module uart_baud_divisor_search_top (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_valid,
    output logic                           o_ready,
    input  wire [ubds_pkg::BAUD_W-1:0]     i_target_baud,
    input  wire [ubds_pkg::CLK_W-1:0]      i_clock_hz,
    input  wire                            i_oversample_by_eight,
    output logic                           o_valid,
    input  wire                            i_ready,
    output logic                           o_found,
    output logic [ubds_pkg::CODE_W-1:0]    o_prescaler_code,
    output logic [ubds_pkg::DREG_W-1:0]    o_divisor_register
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_START = 5'b00010,
        S_WAIT  = 5'b00100,
        S_CHECK = 5'b01000,
        S_EMIT  = 5'b10000
    } t_state;

    // which division the shared divider is working on
    typedef enum logic [2:0] {
        PH_SCLK = 3'b001,
        PH_DIV  = 3'b010,
        PH_GEN  = 3'b100
    } t_phase;

    t_state                         r_state, n_state;
    t_phase                         r_phase, n_phase;
    logic [ubds_pkg::BAUD_W-1:0]    r_baud, n_baud;
    logic [ubds_pkg::CLK_W-1:0]     r_clk_hz, n_clk_hz;
    logic                           r_os8, n_os8;
    logic [ubds_pkg::CODE_W-1:0]    r_code, n_code;
    logic [ubds_pkg::SCLK_W-1:0]    r_sclk, n_sclk;
    logic [ubds_pkg::DREG_W-1:0]    r_div, n_div;
    logic [ubds_pkg::GEN_W-1:0]     r_gen, n_gen;
    logic                           r_found, n_found;
    logic [ubds_pkg::DREG_W-1:0]    r_pack, n_pack;
    logic                           r_out_valid, n_out_valid;
    logic                           r_out_found, n_out_found;
    logic [ubds_pkg::CODE_W-1:0]    r_out_code, n_out_code;
    logic [ubds_pkg::DREG_W-1:0]    r_out_dreg, n_out_dreg;
    ubds_pkg::t_div_req             r_req, n_req;
    ubds_pkg::t_div_rsp             w_rsp;

    logic [ubds_pkg::DVD_W-1:0]     w_q_even;
    logic                           w_in_range;
    logic [ubds_pkg::GEN_W-1:0]     w_baud_ext;
    logic [ubds_pkg::GEN_W-1:0]     w_diff;
    logic [ubds_pkg::TOL_L_W-1:0]   w_lhs;
    logic [ubds_pkg::TOL_L_W-1:0]   w_rhs;
    logic                           w_tol_ok;

    ubds_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_req),
        .o_rsp   (w_rsp)
    );

    // rounded divisor, bit 0 cleared for oversampling by 8
    assign w_q_even   = r_os8 ? {w_rsp.quotient[ubds_pkg::DVD_W-1:1], 1'b0} : w_rsp.quotient;
    assign w_in_range = (w_q_even >= ubds_pkg::DIV_MIN) && (w_q_even <= ubds_pkg::DIV_MAX);

    // tolerance test |baud - gen| * 5000 <= 91 * baud
    assign w_baud_ext = ubds_pkg::GEN_W'(r_baud);
    assign w_diff     = (w_baud_ext >= r_gen) ? (w_baud_ext - r_gen) : (r_gen - w_baud_ext);
    assign w_lhs      = ubds_pkg::TOL_L_W'(w_diff) * ubds_pkg::TOL_L_W'(ubds_pkg::TOL_DEN);
    assign w_rhs      = ubds_pkg::TOL_L_W'(r_baud) * ubds_pkg::TOL_L_W'(ubds_pkg::TOL_NUM);
    assign w_tol_ok   = (w_lhs <= w_rhs);

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_baud      = r_baud;
        n_clk_hz    = r_clk_hz;
        n_os8       = r_os8;
        n_code      = r_code;
        n_sclk      = r_sclk;
        n_div       = r_div;
        n_gen       = r_gen;
        n_found     = r_found;
        n_pack      = r_pack;
        n_out_valid = r_out_valid;
        n_out_found = r_out_found;
        n_out_code  = r_out_code;
        n_out_dreg  = r_out_dreg;
        n_req       = r_req;
        n_req.start = 1'b0;

        // output register drains independently of the search
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_baud   = i_target_baud;
                    n_clk_hz = i_clock_hz;
                    n_os8    = i_oversample_by_eight;
                    n_code   = '0;
                    n_found  = 1'b0;
                    n_pack   = '0;
                    if (i_target_baud == '0) begin
                        // zero baud rate: nothing can be accepted
                        n_code  = ubds_pkg::LAST_CODE;
                        n_state = S_EMIT;
                    end else begin
                        n_state = S_START;
                    end
                end
            end
            S_START: begin
                // scaled clock = (clock, doubled for oversampling by 8) / factor
                n_req.start    = 1'b1;
                n_req.dividend = r_os8 ? {1'b0, r_clk_hz, 1'b0} : {2'b00, r_clk_hz};
                n_req.divisor  = ubds_pkg::DVS_W'(ubds_pkg::presc_factor(r_code));
                n_phase        = PH_SCLK;
                n_state        = S_WAIT;
            end
            S_WAIT: begin
                if (w_rsp.done) begin
                    case (r_phase)
                        PH_SCLK: begin
                            n_sclk         = w_rsp.quotient[ubds_pkg::SCLK_W-1:0];
                            n_req.start    = 1'b1;
                            n_req.dividend = ubds_pkg::DVD_W'(
                                                 w_rsp.quotient[ubds_pkg::SCLK_W-1:0])
                                           + ubds_pkg::DVD_W'(r_baud[ubds_pkg::BAUD_W-1:1]);
                            n_req.divisor  = r_baud;
                            n_phase        = PH_DIV;
                        end
                        PH_DIV: begin
                            if (w_in_range) begin
                                n_div          = w_q_even[ubds_pkg::DREG_W-1:0];
                                n_req.start    = 1'b1;
                                n_req.dividend = ubds_pkg::DVD_W'(r_sclk);
                                n_req.divisor  = ubds_pkg::DVS_W'(
                                                     w_q_even[ubds_pkg::DREG_W-1:0]);
                                n_phase        = PH_GEN;
                            end else if (r_code == ubds_pkg::LAST_CODE) begin
                                n_state = S_EMIT;
                            end else begin
                                n_code  = r_code + 1'b1;
                                n_state = S_START;
                            end
                        end
                        PH_GEN: begin
                            n_gen   = w_rsp.quotient[ubds_pkg::GEN_W-1:0];
                            n_state = S_CHECK;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_CHECK: begin
                if (w_tol_ok) begin
                    n_found = 1'b1;
                    // oversampling by 8 packs the low nibble shifted right by one
                    n_pack  = r_os8 ? {r_div[ubds_pkg::DREG_W-1:4], 1'b0, r_div[3:1]} : r_div;
                    n_state = S_EMIT;
                end else if (r_code == ubds_pkg::LAST_CODE) begin
                    n_state = S_EMIT;
                end else begin
                    n_code  = r_code + 1'b1;
                    n_state = S_START;
                end
            end
            S_EMIT: begin
                // wait until the output register is free or being emptied
                if (!r_out_valid || i_ready) begin
                    n_out_valid = 1'b1;
                    n_out_found = r_found;
                    n_out_code  = r_code;
                    n_out_dreg  = r_pack;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= PH_SCLK;
            r_out_valid <= 1'b0;
            r_req.start <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_out_valid <= n_out_valid;
            r_req.start <= n_req.start;
        end
        r_req.dividend <= n_req.dividend;
        r_req.divisor  <= n_req.divisor;
        r_baud         <= n_baud;
        r_clk_hz       <= n_clk_hz;
        r_os8          <= n_os8;
        r_code         <= n_code;
        r_sclk         <= n_sclk;
        r_div          <= n_div;
        r_gen          <= n_gen;
        r_found        <= n_found;
        r_pack         <= n_pack;
        r_out_found    <= n_out_found;
        r_out_code     <= n_out_code;
        r_out_dreg     <= n_out_dreg;
    end

    assign o_ready            = (r_state == S_IDLE);
    assign o_valid            = r_out_valid;
    assign o_found            = r_out_found;
    assign o_prescaler_code   = r_out_code;
    assign o_divisor_register = r_out_dreg;

endmodule

`default_nettype wire
